FILE: rtl/odnp_pkg.sv
// Shared types, constants and lookup tables for the nibble-pixel ordered dither.
// No dependencies; imported by every module of the block.
`default_nettype none

package odnp_pkg;

  localparam int unsigned NIB_W   = 4;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned BCOL_W  = 2;
  localparam int unsigned COL_W   = BCOL_W + 1;
  localparam int unsigned PAIR_W  = 2 * NIB_W;
  localparam int unsigned LANES   = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DITHER_MODE = 2'd0,
    REG_LIGHT_INDEX = 2'd1,
    REG_DARK_INDEX  = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;
  localparam int unsigned CFG_DATA_W = NIB_W;

  localparam logic             MODE_THRESHOLD  = 1'b0;
  localparam logic             MODE_PATTERN    = 1'b1;
  localparam logic [LEVEL_W-1:0] FIXED_THRESHOLD = 6'd31;

  localparam logic [NIB_W-1:0] LIGHT_RESET = 4'd15;
  localparam logic [NIB_W-1:0] DARK_RESET  = 4'd0;

  // Live configuration handed to every lane
  typedef struct packed {
    logic             mode;
    logic [NIB_W-1:0] light;
    logic [NIB_W-1:0] dark;
  } cfg_t;

  // Color index to 6-bit intensity
  localparam logic [LEVEL_W-1:0] INTENSITY [16] = '{
    6'd0,  6'd4,  6'd24, 6'd29, 6'd12, 6'd17, 6'd24, 6'd42,
    6'd21, 6'd25, 6'd45, 6'd50, 6'd33, 6'd38, 6'd58, 6'd63
  };

  // 8x8 Bayer matrix, indexed by {row, col}
  localparam logic [LEVEL_W-1:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

endpackage : odnp_pkg

`default_nettype wire

FILE: rtl/ordered_dither_nibble_pixels_unit.sv
// Ordered dither of two 4-bit pixels per byte: two judging lanes and a merge stage.
// Accepted results are registered before out_valid. Throughput: one byte per
// cycle without out_stall, set by the single output register; a one-entry skid absorbs stall.
// Reset (rst_n low, synchronous): pipeline empties, mode = threshold,
// light index = 15, dark index = 0. Config port is always ready.
`default_nettype none

module ordered_dither_nibble_pixels_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [odnp_pkg::PAIR_W-1:0]     in_pixel_pair,
  input  wire logic [odnp_pkg::ROW_W-1:0]      in_tile_row,
  input  wire logic [odnp_pkg::BCOL_W-1:0]     in_tile_byte_col,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [odnp_pkg::PAIR_W-1:0]     out_dithered_pair,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [odnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [odnp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import odnp_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [NIB_W-1:0] lane_nib [LANES];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DITHER_MODE: cfg_nxt.mode  = cfg_data[0];
        REG_LIGHT_INDEX: cfg_nxt.light = cfg_data[NIB_W-1:0];
        REG_DARK_INDEX:  cfg_nxt.dark  = cfg_data[NIB_W-1:0];
        default:         cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_THRESHOLD;
      cfg_r.light <= LIGHT_RESET;
      cfg_r.dark  <= DARK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // One lane per nibble; lane 0 takes the high (left) nibble
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    odnp_lane u_lane (
      .nib     (in_pixel_pair[(LANES-1-g)*NIB_W +: NIB_W]),
      .row     (in_tile_row),
      .col     ({in_tile_byte_col, 1'(g)}),
      .cfg     (cfg_r),
      .nib_out (lane_nib[g])
    );
  end

  // Merge and output buffering
  odnp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_nib  (lane_nib),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pair  (out_dithered_pair)
  );

endmodule : ordered_dither_nibble_pixels_unit

`default_nettype wire

FILE: rtl/odnp_lane.sv
// One dither lane: judges a single 4-bit pixel against threshold or Bayer entry.
// Depends on odnp_pkg for the intensity and Bayer tables.
`default_nettype none

module odnp_lane (
  input  wire logic [odnp_pkg::NIB_W-1:0] nib,
  input  wire logic [odnp_pkg::ROW_W-1:0] row,
  input  wire logic [odnp_pkg::COL_W-1:0] col,
  input  wire odnp_pkg::cfg_t             cfg,
  output logic      [odnp_pkg::NIB_W-1:0] nib_out
);
  import odnp_pkg::*;

  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] limit;

  // Table lookups and compare
  always_comb begin
    level   = INTENSITY[nib];
    limit   = (cfg.mode == MODE_PATTERN) ? BAYER[{row, col}] : FIXED_THRESHOLD;
    nib_out = (level > limit) ? cfg.light : cfg.dark;
  end

endmodule : odnp_lane

`default_nettype wire

FILE: rtl/odnp_merge.sv
// Merge stage: packs the lane nibbles into one byte and holds it in an
// output register backed by a skid register. Depends on odnp_pkg.
`default_nettype none

module odnp_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [odnp_pkg::NIB_W-1:0]  lane_nib [odnp_pkg::LANES],
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [odnp_pkg::PAIR_W-1:0] out_pair
);
  import odnp_pkg::*;

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic [PAIR_W-1:0] main_r, main_nxt;
  logic [PAIR_W-1:0] skid_r, skid_nxt;
  logic [PAIR_W-1:0] packed_pair;
  logic              in_xfer;
  logic              out_xfer;

  // Lane 0 is the left pixel in the high nibble
  assign packed_pair = {lane_nib[0], lane_nib[1]};

  assign in_stall  = skid_v_r;
  assign in_xfer   = in_valid && !skid_v_r;
  assign out_xfer  = main_v_r && !out_stall;
  assign out_valid = main_v_r;
  assign out_pair  = main_r;

  // Output register / skid control
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (out_xfer) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      if (main_v_r && !out_xfer) begin
        skid_nxt   = packed_pair;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = packed_pair;
        main_v_nxt = 1'b1;
      end
    end else if (out_xfer) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule : odnp_merge

`default_nettype wire
